[design/mlh_pkg.sv]
// Shared types, constants and codes for the monotone line hull query block.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package mlh_pkg;

    localparam int STACK_DEPTH = 1024;
    localparam int VALUE_WIDTH = 32;

    localparam int VW = VALUE_WIDTH;
    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int DW = VW + 1;
    localparam int QW = VW + 2;
    localparam int PW = 2 * VW + 1;
    localparam int LW = 32;

    localparam logic signed [LW-1:0] QUERY_X_START = 32'sd1000000005;

    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_QUERY  = 2'd1;
    localparam logic [1:0] REQ_CLEAR  = 2'd2;

    localparam logic [2:0] ST_INSERTED  = 3'd0;
    localparam logic [2:0] ST_DROPPED   = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_SLOPE_ERR = 3'd3;
    localparam logic [2:0] ST_X_ERR     = 3'd4;
    localparam logic [2:0] ST_EMPTY     = 3'd5;
    localparam logic [2:0] ST_OK        = 3'd6;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DISPATCH,
        S_RD_TOP,
        S_TOP,
        S_INS_CHK,
        S_RE_CHK,
        S_RE_RD,
        S_RE_TOP,
        S_LOOP,
        S_LOW,
        S_DIV1,
        S_DIV1_W,
        S_DIV2,
        S_DIV2_W,
        S_INS_CMP,
        S_INS_END,
        S_Q_MUL,
        S_Q_CMP,
        S_Q_FIN,
        S_Q_FIN2,
        S_DONE
    } t_state;

    typedef struct packed {
        logic       load_req;
        logic       rd_top;
        logic       rd_low;
        logic       cap_top;
        logic       cap_low;
        logic       dec_n;
        logic       shift_low;
        logic       div_start;
        logic       div_sel;
        logic       cap_x1;
        logic       mul_start;
        logic       mul_sel;
        logic       push;
        logic       commit_q;
        logic       clear;
        logic       out_load;
        logic [2:0] out_code;
        logic       out_best;
    } t_cmd;

    typedef struct packed {
        logic [1:0] req_type;
        logic       n_zero;
        logic       n_ge2;
        logic       n_full;
        logic       cnt_zero;
        logic       x_gt;
        logic       slope_lt;
        logic       slope_eq;
        logic       icpt_le;
        logic       div_done;
        logic       useless;
        logic       q_pop;
        logic       out_free;
    } t_sts;

endpackage

`default_nettype wire

[design/mlh_div.sv]
// Iterative floored divider, one quotient bit per cycle.
// Depends on mlh_pkg for the operand and quotient widths.
`timescale 1ns / 1ps
`default_nettype none

module mlh_div (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic signed [mlh_pkg::DW-1:0] i_num,
    input  wire logic signed [mlh_pkg::DW-1:0] i_den,
    output logic                            o_done,
    output logic signed [mlh_pkg::QW-1:0]   o_quo
);
    import mlh_pkg::*;

    localparam int NW = $clog2(VW + 1);

    logic          r_busy;
    logic          r_done;
    logic          r_zero;
    logic          r_neg;
    logic [VW-1:0] r_quo;
    logic [VW-1:0] r_rem;
    logic [VW-1:0] r_den;
    logic [NW-1:0] r_cnt;

    logic [VW:0]   rem_sh;
    logic [VW+1:0] trial;
    logic [DW-1:0] num_abs;
    logic [QW-1:0] mag;

    always_comb begin
        rem_sh  = {r_rem, r_quo[VW-1]};
        trial   = {1'b0, rem_sh} - {2'b00, r_den};
        num_abs = i_num[DW-1] ? (-i_num) : i_num;
        mag     = {2'b00, r_quo} + QW'(r_rem != '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= NW'(VW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == NW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_zero <= (i_den[DW-1] || (i_den == '0));
            r_neg  <= i_num[DW-1];
            r_quo  <= num_abs[VW-1:0];
            r_den  <= i_den[VW-1:0];
            r_rem  <= '0;
        end else if (r_busy) begin
            if (!trial[VW+1]) begin
                r_rem <= trial[VW-1:0];
                r_quo <= {r_quo[VW-2:0], 1'b1};
            end else begin
                r_rem <= rem_sh[VW-1:0];
                r_quo <= {r_quo[VW-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_zero ? '0 : (r_neg ? -$signed(mag) : $signed({2'b00, r_quo}));

endmodule

`default_nettype wire

[design/mlh_ctrl.sv]
// Sequencing state machine of the line hull block.
// Depends on mlh_pkg for the state, command and status types.
`timescale 1ns / 1ps
`default_nettype none

module mlh_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_req_valid,
    output logic               o_req_ready,
    input  wire mlh_pkg::t_sts i_sts,
    output mlh_pkg::t_cmd      o_cmd
);
    import mlh_pkg::*;

    t_state     r_state, n_state;
    logic [2:0] r_code, n_code;
    logic       r_best, n_best;
    t_cmd       cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_code  <= ST_OK;
            r_best  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_code  <= n_code;
            r_best  <= n_best;
        end
    end

    always_comb begin
        n_state = r_state;
        n_code  = r_code;
        n_best  = r_best;
        cmd     = '0;
        cmd.out_code = r_code;
        cmd.out_best = r_best;
        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    cmd.load_req = 1'b1;
                    n_state      = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                n_best  = 1'b0;
                n_code  = ST_OK;
                n_state = S_DONE;
                case (i_sts.req_type)
                    REQ_INSERT: begin
                        n_state = i_sts.n_zero ? S_INS_END : S_RD_TOP;
                    end
                    REQ_QUERY: begin
                        if (i_sts.x_gt) begin
                            n_code = ST_X_ERR;
                        end else if (i_sts.cnt_zero) begin
                            n_code = ST_EMPTY;
                        end else begin
                            n_state = S_RD_TOP;
                        end
                    end
                    REQ_CLEAR: begin
                        cmd.clear = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
            S_RD_TOP: begin
                cmd.rd_top = 1'b1;
                n_state    = S_TOP;
            end
            S_TOP: begin
                cmd.cap_top = 1'b1;
                n_state = (i_sts.req_type == REQ_INSERT) ? S_INS_CHK : S_LOOP;
            end
            S_INS_CHK: begin
                if (i_sts.slope_lt) begin
                    n_code  = ST_SLOPE_ERR;
                    n_state = S_DONE;
                end else if (i_sts.slope_eq && i_sts.icpt_le) begin
                    n_code  = ST_DROPPED;
                    n_state = S_DONE;
                end else if (i_sts.slope_eq) begin
                    cmd.dec_n = 1'b1;
                    n_state   = S_RE_CHK;
                end else begin
                    n_state = S_LOOP;
                end
            end
            S_RE_CHK: begin
                n_state = i_sts.n_zero ? S_INS_END : S_RE_RD;
            end
            S_RE_RD: begin
                cmd.rd_top = 1'b1;
                n_state    = S_RE_TOP;
            end
            S_RE_TOP: begin
                cmd.cap_top = 1'b1;
                n_state     = S_LOOP;
            end
            S_LOOP: begin
                if (i_sts.n_ge2) begin
                    cmd.rd_low = 1'b1;
                    n_state    = S_LOW;
                end else begin
                    n_state = (i_sts.req_type == REQ_INSERT) ? S_INS_END : S_Q_FIN;
                end
            end
            S_LOW: begin
                cmd.cap_low = 1'b1;
                n_state = (i_sts.req_type == REQ_INSERT) ? S_DIV1 : S_Q_MUL;
            end
            S_DIV1: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = 1'b0;
                n_state       = S_DIV1_W;
            end
            S_DIV1_W: begin
                if (i_sts.div_done) begin
                    cmd.cap_x1 = 1'b1;
                    n_state    = S_DIV2;
                end
            end
            S_DIV2: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = 1'b1;
                n_state       = S_DIV2_W;
            end
            S_DIV2_W: begin
                if (i_sts.div_done) begin
                    n_state = S_INS_CMP;
                end
            end
            S_INS_CMP: begin
                if (i_sts.useless) begin
                    cmd.dec_n     = 1'b1;
                    cmd.shift_low = 1'b1;
                    n_state       = S_LOOP;
                end else begin
                    n_state = S_INS_END;
                end
            end
            S_INS_END: begin
                n_state = S_DONE;
                if (i_sts.n_full) begin
                    n_code = ST_FULL;
                end else begin
                    cmd.push = 1'b1;
                    n_code   = ST_INSERTED;
                end
            end
            S_Q_MUL: begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = 1'b0;
                n_state       = S_Q_CMP;
            end
            S_Q_CMP: begin
                if (i_sts.q_pop) begin
                    cmd.dec_n     = 1'b1;
                    cmd.shift_low = 1'b1;
                    n_state       = S_LOOP;
                end else begin
                    n_state = S_Q_FIN;
                end
            end
            S_Q_FIN: begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = 1'b1;
                n_state       = S_Q_FIN2;
            end
            S_Q_FIN2: begin
                cmd.commit_q = 1'b1;
                n_code       = ST_OK;
                n_best       = 1'b1;
                n_state      = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    cmd.out_load = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_cmd       = cmd;
    assign o_req_ready = (r_state == S_IDLE);

endmodule

`default_nettype wire

[design/mlh_dp.sv]
// Datapath of the line hull block: line memory, working registers,
// multiplier, divider and result register. Depends on mlh_pkg and mlh_div.
`timescale 1ns / 1ps
`default_nettype none

module mlh_dp (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire mlh_pkg::t_cmd           i_cmd,
    output mlh_pkg::t_sts                o_sts,
    input  wire logic [1:0]              i_req_type,
    input  wire logic [31:0]             i_slope,
    input  wire logic [31:0]             i_intercept,
    input  wire logic [31:0]             i_query_x,
    output logic                         o_res_valid,
    input  wire logic                    i_res_ready,
    output logic signed [63:0]           o_best_value,
    output logic [2:0]                   o_status,
    output logic [mlh_pkg::CW-1:0]       o_line_count
);
    import mlh_pkg::*;

    logic [2*VW-1:0]       r_mem [STACK_DEPTH];
    logic [2*VW-1:0]       r_rd;
    logic [AW-1:0]         rd_addr;

    logic [1:0]            r_type;
    logic signed [VW-1:0]  r_s, r_b, r_x;
    logic signed [VW-1:0]  r_ms, r_mb, r_ls, r_lb;
    logic [CW-1:0]         r_n, r_count;
    logic signed [LW-1:0]  r_last;
    logic signed [QW-1:0]  r_x1;
    logic signed [PW-1:0]  r_prod;
    logic                  r_out_valid;

    logic signed [DW-1:0]  ds_ml, db_lm, div_num, div_den, mul_op;
    logic signed [QW-1:0]  div_q;
    logic                  div_done;
    logic signed [PW-1:0]  best_sum;

    always_comb begin
        rd_addr  = i_cmd.rd_low ? AW'(r_n - CW'(2)) : AW'(r_n - CW'(1));
        ds_ml    = DW'(r_ms) - DW'(r_ls);
        db_lm    = DW'(r_lb) - DW'(r_mb);
        div_num  = i_cmd.div_sel ? (DW'(r_mb) - DW'(r_b)) : db_lm;
        div_den  = i_cmd.div_sel ? (DW'(r_s) - DW'(r_ms)) : ds_ml;
        mul_op   = i_cmd.mul_sel ? DW'(r_ms) : ds_ml;
        best_sum = r_prod + PW'(r_mb);
    end

    mlh_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_q)
    );

    // Line memory: one write port for pushes, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_mem[r_n[AW-1:0]] <= {r_s, r_b};
        end
        if (i_cmd.rd_top || i_cmd.rd_low) begin
            r_rd <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_type <= i_req_type;
            r_s    <= $signed(i_slope[VW-1:0]);
            r_b    <= $signed(i_intercept[VW-1:0]);
            r_x    <= $signed(i_query_x[VW-1:0]);
        end
        if (i_cmd.cap_top) begin
            r_ms <= $signed(r_rd[2*VW-1:VW]);
            r_mb <= $signed(r_rd[VW-1:0]);
        end else if (i_cmd.shift_low) begin
            r_ms <= r_ls;
            r_mb <= r_lb;
        end
        if (i_cmd.cap_low) begin
            r_ls <= $signed(r_rd[2*VW-1:VW]);
            r_lb <= $signed(r_rd[VW-1:0]);
        end
        if (i_cmd.cap_x1) begin
            r_x1 <= div_q;
        end
        if (i_cmd.mul_start) begin
            r_prod <= r_x * mul_op;
        end
        if (i_cmd.load_req) begin
            r_n <= r_count;
        end else if (i_cmd.dec_n) begin
            r_n <= r_n - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_last      <= QUERY_X_START;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.push) begin
                r_count <= r_n + 1'b1;
            end else if (i_cmd.commit_q) begin
                r_count <= r_n;
            end else if (i_cmd.clear) begin
                r_count <= '0;
            end
            if (i_cmd.commit_q) begin
                r_last <= LW'(r_x);
            end else if (i_cmd.clear) begin
                r_last <= QUERY_X_START;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_best_value <= i_cmd.out_best ? 64'(best_sum) : '0;
            o_status     <= i_cmd.out_code;
            o_line_count <= r_count;
        end
    end

    always_comb begin
        o_sts.req_type = r_type;
        o_sts.n_zero   = (r_n == '0);
        o_sts.n_ge2    = (r_n >= CW'(2));
        o_sts.n_full   = (r_n >= CW'(STACK_DEPTH));
        o_sts.cnt_zero = (r_count == '0);
        o_sts.x_gt     = (LW'(r_x) > r_last);
        o_sts.slope_lt = (r_s < r_ms);
        o_sts.slope_eq = (r_s == r_ms);
        o_sts.icpt_le  = (r_b <= r_mb);
        o_sts.div_done = div_done;
        o_sts.useless  = (r_x1 >= div_q);
        o_sts.q_pop    = (r_prod <= PW'(db_lm));
        o_sts.out_free = !r_out_valid || i_res_ready;
    end

    assign o_res_valid = r_out_valid;

endmodule

`default_nettype wire

[design/monotone_line_hull_max_query.sv]
// Top level of the monotone line hull block: controller plus datapath.
// Depends on mlh_pkg, mlh_ctrl and mlh_dp.
`timescale 1ns / 1ps
`default_nettype none

// This block keeps the upper hull of a set of lines y = slope*x + intercept on a
// stack of up to 1024 lines and answers maximum queries at falling x. Each request
// is an insert, a query or a clear, and each request gives exactly one result with
// a status code and the line count left on the stack. Inserts must come with
// non-decreasing slopes and queries with non-increasing x; violations, an empty
// stack and a full stack are reported in the status instead of changing state.
// Requests are handled one at a time. A clear, an unused request code or a rejected
// query goes straight to its result. An insert on an empty stack is pushed without
// reading the stack. Any other insert first reads the top line; when an equal slope
// replaces the top line, the next line is read as well. Each hull test runs two
// floored divisions, one quotient bit per cycle, through a single shared divider.
// A query tests its lines through the registered multiplier and the single read
// port of the line memory. Lines removed by either kind of request are tested only
// once, so over a long stream the cost per request stays bounded. A new request is
// taken while an earlier result still waits at the output; its own result then
// waits in the final state until the output register has been emptied.

module monotone_line_hull_max_query (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_req_valid,
    output logic                       o_req_ready,
    input  wire logic [1:0]            i_req_type,
    input  wire logic [31:0]           i_slope,
    input  wire logic [31:0]           i_intercept,
    input  wire logic [31:0]           i_query_x,
    output logic                       o_res_valid,
    input  wire logic                  i_res_ready,
    output logic signed [63:0]         o_best_value,
    output logic [2:0]                 o_status,
    output logic [mlh_pkg::CW-1:0]     o_line_count
);
    import mlh_pkg::*;

    // Commands from the sequencer and status flags back from the datapath.
    t_cmd cmd;
    t_sts sts;

    mlh_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    mlh_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_req_type   (i_req_type),
        .i_slope      (i_slope),
        .i_intercept  (i_intercept),
        .i_query_x    (i_query_x),
        .o_res_valid  (o_res_valid),
        .i_res_ready  (i_res_ready),
        .o_best_value (o_best_value),
        .o_status     (o_status),
        .o_line_count (o_line_count)
    );

endmodule

`default_nettype wire

[design/mlh_chk.sv]
// Port-level checks for the monotone line hull block, bound to its top level.
// Depends on mlh_pkg for the status codes and stack depth.
`timescale 1ns / 1ps
`default_nettype none

module mlh_chk (
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  o_res_valid,
    input wire logic                  i_res_ready,
    input wire logic signed [63:0]    o_best_value,
    input wire logic [2:0]            o_status,
    input wire logic [mlh_pkg::CW-1:0] o_line_count
);
    import mlh_pkg::*;

    // A waiting result holds until it is taken.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !i_res_ready |=> o_res_valid && $stable(o_status)
        && $stable(o_best_value) && $stable(o_line_count))
        else $error("result changed while stalled");

    // Only a successful query carries a value.
    a_best: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_status != ST_OK |-> o_best_value == '0)
        else $error("value on a non-query result");

    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> o_line_count <= CW'(STACK_DEPTH))
        else $error("line count above the stack depth");

    // A full report means the stack really is at its depth.
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_status == ST_FULL |-> o_line_count == CW'(STACK_DEPTH))
        else $error("full reported on a stack that is not full");

endmodule

bind monotone_line_hull_max_query mlh_chk u_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_res_valid  (o_res_valid),
    .i_res_ready  (i_res_ready),
    .o_best_value (o_best_value),
    .o_status     (o_status),
    .o_line_count (o_line_count)
);

`default_nettype wire
